// ===== src/extended_gcd_mod_inverse_defines.svh =====
// assertion macros for the extended gcd / modular inverse block
// used by the checker module only
`ifndef EXTENDED_GCD_MOD_INVERSE_DEFINES_SVH
`define EXTENDED_GCD_MOD_INVERSE_DEFINES_SVH
// clocked implication with async reset disable
`define EGMI_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egmi check failed");
// next-cycle implication
`define EGMI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egmi check failed");
`endif

// ===== src/egmi_pkg.sv =====
// shared types and constants for the extended gcd / modular inverse block
// no dependencies
package egmi_pkg;
	localparam int unsigned W = 64;
	localparam int unsigned QW = 7;
	localparam logic KIND_GCD = 1'b0;
	localparam logic KIND_INV = 1'b1;

	// shift-subtract divider unit commands and status
	typedef struct packed {
		logic          start;
		logic [W-1:0]  dividend;
		logic [W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [W-1:0]  quo;
		logic [W-1:0]  rem;
	} div_rsp_t;
endpackage

// ===== src/egmi_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on egmi_pkg
module egmi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  egmi_pkg::div_req_t  req,
	output egmi_pkg::div_rsp_t  rsp
);
	logic [egmi_pkg::W-1:0] rem_q, quo_q, dvs_q;
	logic [egmi_pkg::QW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [egmi_pkg::W:0] trial;
	logic [egmi_pkg::W-1:0] rsh;

	always_comb begin
		rsh = {rem_q[egmi_pkg::W-2:0], quo_q[egmi_pkg::W-1]};
		trial = {rem_q[egmi_pkg::W-1], rsh} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= req.dividend;
				dvs_q <= req.divisor;
			end else if (busy_q) begin
				if (!trial[egmi_pkg::W]) begin
					rem_q <= trial[egmi_pkg::W-1:0];
					quo_q <= {quo_q[egmi_pkg::W-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[egmi_pkg::W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == egmi_pkg::QW'(egmi_pkg::W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;
endmodule

// ===== src/extended_gcd_mod_inverse.sv =====
// top level: extended gcd and modular inverse on signed 64-bit operands
// depends on egmi_pkg and egmi_div
//
// usage:
//   s_axis carries one item: kind, operand_a, operand_b. m_axis carries one
//   result item per input item: gcd_value, coeff_x, coeff_y, inverse, valid_res.
//   s_axis_tready is high only while the block is idle and no result waits.
//   an item passes through reduction (inverse kind), then Euclid steps.
//   each Euclid step starts the shared divider, waits for its quotient and
//   remainder, then updates the coefficients by shift-add over the quotient
//   bits. reduction and the final modulo of the inverse each add one divide.
//   latency is data dependent; worst case near 92 Euclid steps.
//   one item is in flight at a time, so throughput is one item per latency.
//   the result is held in an output register until m_axis_tready is high;
//   no new item is accepted before that.
//   reset clears the sequencer and drops m_axis_tvalid.
module extended_gcd_mod_inverse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // operand_a, operand_b
	input  logic          s_axis_tuser,  // kind
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [255:0]  m_axis_tdata,  // gcd_value, coeff_x, coeff_y, inverse, zero fill
	output logic          m_axis_tuser   // valid_res
);
	localparam int unsigned W = egmi_pkg::W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RED, ST_REDW, ST_LOOP, ST_DIVW, ST_MUL, ST_FIX, ST_FIXW, ST_OUT
	} state_t;

	state_t state_q;
	logic kind_q, an_q, bn_q;
	logic [W-1:0] r0_q, r1_q, s0_q, s1_q, t0_q, t1_q, m_q, q_q, ps_q, pt_q;
	logic [W-1:0] ms_q, mt_q;
	logic [62:0] gcd_q, inv_q;
	logic [W-1:0] x_q, y_q;
	logic vld_q, ovalid_q, aneg_q;
	egmi_pkg::div_req_t dreq;
	egmi_pkg::div_rsp_t drsp;

	logic [W-1:0] a_in, b_in, ma, mb;
	assign a_in = s_axis_tdata[63:0];
	assign b_in = s_axis_tdata[127:64];
	assign ma = a_in[W-1] ? (~a_in + 1'b1) : a_in;
	assign mb = b_in[W-1] ? (~b_in + 1'b1) : b_in;

	egmi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = r0_q;
		dreq.divisor = r1_q;
		unique case (state_q)
			ST_RED: begin
				dreq.start = 1'b1;
				dreq.dividend = r0_q;
				dreq.divisor = m_q;
			end
			ST_LOOP: dreq.start = (r1_q != '0);
			ST_FIX: begin
				dreq.start = 1'b1;
				dreq.dividend = s0_q[W-1] ? (~s0_q + 1'b1) : s0_q;
				dreq.divisor = m_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q <= s_axis_tuser;
						an_q <= a_in[W-1];
						bn_q <= b_in[W-1];
						gcd_q <= '0; x_q <= '0; y_q <= '0; inv_q <= '0; vld_q <= 1'b0;
						s0_q <= W'(1); s1_q <= '0; t0_q <= '0; t1_q <= W'(1);
						if (s_axis_tuser == egmi_pkg::KIND_GCD) begin
							r0_q <= ma; r1_q <= mb;
							if (a_in == {1'b1, {(W-1){1'b0}}} || b_in == {1'b1, {(W-1){1'b0}}})
								state_q <= ST_OUT;
							else if (ma == '0) begin
								gcd_q <= mb[62:0];
								y_q <= b_in[W-1] ? '1 : W'(1);
								vld_q <= 1'b1;
								state_q <= ST_OUT;
							end else if (mb == '0) begin
								gcd_q <= ma[62:0];
								x_q <= a_in[W-1] ? '1 : W'(1);
								vld_q <= 1'b1;
								state_q <= ST_OUT;
							end else
								state_q <= ST_LOOP;
						end else begin
							m_q <= b_in;
							r0_q <= ma;
							aneg_q <= a_in[W-1];
							if (b_in[W-1] || b_in == '0)
								state_q <= ST_OUT;
							else
								state_q <= ST_RED;
						end
					end
				end
				ST_RED: state_q <= ST_REDW;
				ST_REDW: begin
					if (drsp.done) begin
						if (drsp.rem == '0)
							state_q <= ST_OUT;
						else begin
							r0_q <= aneg_q ? (m_q - drsp.rem) : drsp.rem;
							r1_q <= m_q;
							state_q <= ST_LOOP;
						end
					end
				end
				ST_LOOP: begin
					if (r1_q == '0) begin
						if (kind_q == egmi_pkg::KIND_GCD) begin
							gcd_q <= r0_q[62:0];
							x_q <= an_q ? (~s0_q + 1'b1) : s0_q;
							y_q <= bn_q ? (~t0_q + 1'b1) : t0_q;
							vld_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (r0_q == W'(1))
							state_q <= ST_FIX;
						else
							state_q <= ST_OUT;
					end else
						state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (drsp.done) begin
						q_q <= drsp.quo;
						r0_q <= r1_q;
						r1_q <= drsp.rem;
						ms_q <= s1_q;
						mt_q <= t1_q;
						ps_q <= '0;
						pt_q <= '0;
						state_q <= ST_MUL;
					end
				end
				// shift-add of quotient times s1 and t1, lsb first
				ST_MUL: begin
					if (q_q == '0) begin
						s0_q <= s1_q;
						t0_q <= t1_q;
						s1_q <= s0_q - ps_q;
						t1_q <= t0_q - pt_q;
						state_q <= ST_LOOP;
					end else begin
						if (q_q[0]) begin
							ps_q <= ps_q + ms_q;
							pt_q <= pt_q + mt_q;
						end
						ms_q <= ms_q << 1;
						mt_q <= mt_q << 1;
						q_q <= q_q >> 1;
					end
				end
				ST_FIX: state_q <= ST_FIXW;
				ST_FIXW: begin
					if (drsp.done) begin
						if (s0_q[W-1] && drsp.rem != '0)
							inv_q <= 63'(m_q - drsp.rem);
						else
							inv_q <= drsp.rem[62:0];
						vld_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q)
						ovalid_q <= 1'b1;
					else if (m_axis_tready) begin
						ovalid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b0, inv_q, y_q, x_q, gcd_q};
	assign m_axis_tuser = vld_q;
endmodule

// ===== src/egmi_checker.sv =====
// port-level checker for the extended gcd / modular inverse block
// depends on extended_gcd_mod_inverse_defines.svh; bound to the top level
`include "extended_gcd_mod_inverse_defines.svh"
module egmi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_axis_tvalid,
	input logic          s_axis_tready,
	input logic          m_axis_tvalid,
	input logic          m_axis_tready,
	input logic [255:0]  m_axis_tdata,
	input logic          m_axis_tuser
);
	`EGMI_ASSERT(a_one_side, m_axis_tvalid, !s_axis_tready)
	`EGMI_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`EGMI_ASSERT(a_reject_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
	`EGMI_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind extended_gcd_mod_inverse egmi_checker u_chk (.*);

// ===== test/testbench.sv =====
// self-checking testbench for extended_gcd_mod_inverse: extended gcd and modular inverse
// depends on egmi_pkg and the block's rtl; predicts each result in place and compares in order
module testbench;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam int RANDOM_ITEMS = 1580;
	localparam longint CYCLE_LIMIT = 60_000_000;
	localparam int HOLD_CYCLES = 20000;
	localparam int DRAIN_CYCLES = 8000;

	typedef struct {
		logic        kind;
		logic [63:0] a;
		logic [63:0] b;
	} operands_t;

	typedef struct {
		logic [62:0] gcd;
		logic [63:0] x;
		logic [63:0] y;
		logic [62:0] inv;
		logic        ok;
	} gcd_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [255:0] m_axis_tdata;
	logic m_axis_tuser;

	operands_t pending_items[$];
	gcd_result_t expected_results[$];
	operands_t offered;
	bit taken;
	bit hold_done;
	int hold_left;
	int n_accepted;
	int n_total;
	int n_results;
	int n_valid;
	int n_inverse;
	int n_errors;
	longint cycles;

	extended_gcd_mod_inverse DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic void euclid_run(input logic [63:0] a, input logic [63:0] b,
			output logic [63:0] g, output logic [63:0] s, output logic [63:0] t);
		logic [63:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
		r0 = a; r1 = b; s0 = 64'd1; s1 = 64'd0; t0 = 64'd0; t1 = 64'd1;
		while (r1 != 0) begin
			q = r0 / r1;
			rn = r0 - q * r1;
			sn = s0 - q * s1;
			tn = t0 - q * t1;
			r0 = r1; r1 = rn;
			s0 = s1; s1 = sn;
			t0 = t1; t1 = tn;
		end
		g = r0; s = s0; t = t0;
	endfunction

	function automatic logic [63:0] floor_mod(input logic [63:0] v, input logic [63:0] m);
		logic [63:0] r;
		if (!v[63])
			return v % m;
		r = (64'd0 - v) % m;
		return (r != 0) ? m - r : 64'd0;
	endfunction

	function automatic gcd_result_t predict_result(input operands_t it);
		gcd_result_t res;
		logic [63:0] ma, mb, g, s, t, ar;
		res = '{default: '0};
		if (it.kind == egmi_pkg::KIND_GCD) begin
			if (it.a != MIN64 && it.b != MIN64) begin
				ma = it.a[63] ? 64'd0 - it.a : it.a;
				mb = it.b[63] ? 64'd0 - it.b : it.b;
				res.ok = 1'b1;
				if (ma == 0) begin
					res.gcd = mb[62:0];
					res.y = it.b[63] ? '1 : 64'd1;
				end else if (mb == 0) begin
					res.gcd = ma[62:0];
					res.x = it.a[63] ? '1 : 64'd1;
				end else begin
					euclid_run(ma, mb, g, s, t);
					res.gcd = g[62:0];
					res.x = it.a[63] ? 64'd0 - s : s;
					res.y = it.b[63] ? 64'd0 - t : t;
				end
			end
		end else if (!it.b[63] && it.b != 0) begin
			ar = floor_mod(it.a, it.b);
			if (ar != 0) begin
				euclid_run(ar, it.b, g, s, t);
				if (g == 1) begin
					ma = floor_mod(s, it.b);
					res.inv = ma[62:0];
					res.ok = 1'b1;
				end
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		int width;
		case ($urandom_range(19))
			0: return '0;
			1: return $urandom_range(1) ? MIN64 : MAX64;
			2: return $urandom_range(1) ? 64'd1 : '1;
			default: begin
				v = {$urandom, $urandom};
				width = ($urandom_range(99) < 85) ? $urandom_range(14, 1) : $urandom_range(64, 1);
				v = v >> (64 - width);
				if ($urandom_range(1))
					v = 64'd0 - v;
				return v;
			end
		endcase
	endfunction

	task automatic add_item(input logic kind, input logic [63:0] a, input logic [63:0] b);
		operands_t it;
		it.kind = kind; it.a = a; it.b = b;
		pending_items = {pending_items, it};
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// input side: record accepted items and their predicted results
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_results = {expected_results, predict_result(offered)};
			n_accepted++;
			taken = 1'b1;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || taken)) begin
			taken = 1'b0;
			if (pending_items.size() > 0 &&
					((n_accepted >= 600 && n_accepted < 800) || $urandom_range(99) >= 35)) begin
				offered = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {offered.b, offered.a};
				s_axis_tuser <= offered.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver readiness, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= 300) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (n_accepted >= 600 && n_accepted < 800) ||
					($urandom_range(99) >= 35);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		gcd_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result item with no expectation waiting");
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[62:0] !== want.gcd) begin
					$error("gcd_value expected %0h got %0h", want.gcd, m_axis_tdata[62:0]);
					n_errors++;
				end
				if (m_axis_tdata[126:63] !== want.x) begin
					$error("coeff_x expected %0h got %0h", want.x, m_axis_tdata[126:63]);
					n_errors++;
				end
				if (m_axis_tdata[190:127] !== want.y) begin
					$error("coeff_y expected %0h got %0h", want.y, m_axis_tdata[190:127]);
					n_errors++;
				end
				if (m_axis_tdata[253:191] !== want.inv) begin
					$error("inverse expected %0h got %0h", want.inv, m_axis_tdata[253:191]);
					n_errors++;
				end
				if (m_axis_tuser !== want.ok) begin
					$error("valid_res expected %0b got %0b", want.ok, m_axis_tuser);
					n_errors++;
				end
				if (want.ok)
					n_valid++;
				if (want.ok && want.inv != 0)
					n_inverse++;
			end
		end
	end

	initial begin
		logic kind;
		logic [63:0] a, b;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		taken = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		n_accepted = 0;
		n_results = 0;
		n_valid = 0;
		n_inverse = 0;
		n_errors = 0;
		cycles = 0;

		// gcd kind: zeros, most negative, signs, extremes
		add_item(egmi_pkg::KIND_GCD, 64'd0, 64'd0);
		add_item(egmi_pkg::KIND_GCD, 64'd0, 64'd5);
		add_item(egmi_pkg::KIND_GCD, 64'd0, -64'sd5);
		add_item(egmi_pkg::KIND_GCD, -64'sd7, 64'd0);
		add_item(egmi_pkg::KIND_GCD, MIN64, 64'd3);
		add_item(egmi_pkg::KIND_GCD, 64'd3, MIN64);
		add_item(egmi_pkg::KIND_GCD, MAX64, MAX64 - 1);
		add_item(egmi_pkg::KIND_GCD, MAX64, 64'd0 - MAX64);
		add_item(egmi_pkg::KIND_GCD, 64'd240, 64'd46);
		add_item(egmi_pkg::KIND_GCD, -64'sd240, 64'd46);
		add_item(egmi_pkg::KIND_GCD, 64'd240, -64'sd46);
		add_item(egmi_pkg::KIND_GCD, 64'd1, 64'd1);
		// inverse kind: good, negative operand, bad modulus, non-coprime, extremes
		add_item(egmi_pkg::KIND_INV, 64'd3, 64'd7);
		add_item(egmi_pkg::KIND_INV, -64'sd3, 64'd7);
		add_item(egmi_pkg::KIND_INV, 64'd3, 64'd0);
		add_item(egmi_pkg::KIND_INV, 64'd3, -64'sd7);
		add_item(egmi_pkg::KIND_INV, 64'd14, 64'd7);
		add_item(egmi_pkg::KIND_INV, 64'd5, 64'd1);
		add_item(egmi_pkg::KIND_INV, 64'd6, 64'd9);
		add_item(egmi_pkg::KIND_INV, MIN64, MAX64);
		add_item(egmi_pkg::KIND_INV, MAX64, MIN64);
		add_item(egmi_pkg::KIND_INV, '1, MAX64);
		add_item(egmi_pkg::KIND_INV, MAX64 - 1, MAX64);
		add_item(egmi_pkg::KIND_INV, MIN64 + 1, 64'd1_000_000_007);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = 1'($urandom_range(1));
			a = rand_operand();
			b = rand_operand();
			if (kind == egmi_pkg::KIND_INV && b[63] && $urandom_range(4) != 0)
				b = 64'd0 - b;
			add_item(kind, a, b);
		end
		n_total = pending_items.size();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		wait (n_accepted == n_total);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d items in %0d cycles: %0d results, %0d valid, %0d inverses",
			n_accepted, cycles, n_results, n_valid, n_inverse);
		$display("both kinds with rejects, sign cases and one long output stall");
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/egmi_pkg.sv
src/egmi_div.sv
src/extended_gcd_mod_inverse.sv
src/egmi_checker.sv
test/testbench.sv
